// ----- hw/rtl/fipa_pkg.sv -----
// ----------------------------------------------------------------------------
// fipa_pkg - shared types and codes of the identifier pool allocator
// Request and response codes, field widths and the control bundle that the
// sequencer broadcasts to every cell of the list.
// ----------------------------------------------------------------------------
`default_nettype none

package fipa_pkg;

   localparam int ID_W  = 8;
   localparam int ACT_W = 2;
   localparam int STA_W = 2;

   // request actions
   localparam logic [ACT_W-1:0] ACT_ALLOC  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_RETURN = 2'd1;
   localparam logic [ACT_W-1:0] ACT_FREE   = 2'd2;
   localparam logic [ACT_W-1:0] ACT_RSVD   = 2'd3;

   // response status codes
   localparam logic [STA_W-1:0] STAT_GRANTED   = 2'd0;
   localparam logic [STA_W-1:0] STAT_NONE_FREE = 2'd1;
   localparam logic [STA_W-1:0] STAT_RELEASED  = 2'd2;
   localparam logic [STA_W-1:0] STAT_NOT_FOUND = 2'd3;

   // broadcast from the sequencer to all cells
   typedef struct packed {
      logic             start;    // new request: token to head cell
      logic             advance;  // chain steps this cycle
      logic             finish;   // request completes on this step
      logic             hit_any;  // some cell matched this cycle
      logic [ACT_W-1:0] op;
      logic [ID_W-1:0]  ident;
   } fipa_ctl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/fipa_if.sv -----
// ----------------------------------------------------------------------------
// fipa_if - request and response channels of the identifier pool allocator
// Valid/ready channels; a beat moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
`default_nettype none

interface fipa_req_if;
   logic                        valid;
   logic                        ready;
   logic [fipa_pkg::ACT_W-1:0]  action;
   logic [fipa_pkg::ID_W-1:0]   ident;

   modport source (output valid, output action, output ident, input ready);
   modport sink   (input valid, input action, input ident, output ready);
endinterface

interface fipa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [fipa_pkg::STA_W-1:0]  status;
   logic [fipa_pkg::ID_W-1:0]   granted_ident;

   modport source (output valid, output status, output granted_ident, input ready);
   modport sink   (input valid, input status, input granted_ident, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fipa_cell.sv -----
// ----------------------------------------------------------------------------
// fipa_cell - one list position of the identifier pool
// Holds an identifier and its used mark, passes the search token to the next
// cell, and takes its successor's contents when the list closes a gap.
// ----------------------------------------------------------------------------
`default_nettype none

module fipa_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire fipa_pkg::fipa_ctl_type      ctl,
   input  wire logic                        prv_tok,
   input  wire logic [fipa_pkg::ID_W-1:0]   nxt_slot,
   input  wire logic                        nxt_used,
   output logic      [fipa_pkg::ID_W-1:0]   slot,
   output logic                             used,
   output logic                             tok,
   output logic                             hit
);

   logic [fipa_pkg::ID_W-1:0] slot_ff, slot_in;
   logic                      used_ff, used_in;
   logic                      tok_ff, tok_in;
   logic                      seen_ff, seen_in;
   logic                      match;
   logic                      shift;

   always_comb begin
      case (ctl.op)
         fipa_pkg::ACT_ALLOC:  match = !used_ff;
         fipa_pkg::ACT_RETURN: match = used_ff && (slot_ff == ctl.ident);
         fipa_pkg::ACT_FREE:   match = used_ff && (slot_ff == ctl.ident);
         default:              match = 1'b0;
      endcase
   end

   assign hit = tok_ff & match;

   // cells at or behind the token (not yet passed) move up on free-to-back
   assign shift = ctl.advance & ctl.hit_any & (ctl.op == fipa_pkg::ACT_FREE)
                  & (tok_ff | !seen_ff);

   always_comb begin
      slot_in = slot_ff;
      used_in = used_ff;
      tok_in  = tok_ff;
      seen_in = seen_ff;
      if (ctl.start) begin
         tok_in  = (INDEX == 0);
         seen_in = 1'b0;
      end else if (ctl.advance) begin
         seen_in = seen_ff | tok_ff;
         tok_in  = ctl.finish ? 1'b0 : prv_tok;
         if (shift) begin
            slot_in = nxt_slot;
            used_in = nxt_used;
         end else if (hit) begin
            case (ctl.op)
               fipa_pkg::ACT_ALLOC:  used_in = 1'b1;
               fipa_pkg::ACT_RETURN: used_in = 1'b0;
               default:              used_in = used_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= fipa_pkg::ID_W'(INDEX + 1);
         used_ff <= 1'b0;
         tok_ff  <= 1'b0;
         seen_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         used_ff <= used_in;
         tok_ff  <= tok_in;
         seen_ff <= seen_in;
      end
   end

   assign slot = slot_ff;
   assign used = used_ff;
   assign tok  = tok_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/fifo_id_pool_allocator.sv -----
// Scan: a request matching list position k gives its response beat once the token
//   reaches cell k; a request with no match walks the whole list, and the reserved
//   action finishes on its first step. The search token walks one cell per cycle
//   while the previous response beat is not held by the sink. The next request is
//   accepted once the result is registered, while that beat may still wait for the sink.
// Reset: synchronous; the list reloads as 1..POOL_SIZE ascending, all unused.
// ----------------------------------------------------------------------------
// fifo_id_pool_allocator - ordered identifier pool, first-free grant
// A row of cells holds the identifier list; a token scans it for the first
// unused or the matching used entry, and free-to-back shifts the tail up.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_id_pool_allocator #(
   parameter int POOL_SIZE = 254
) (
   input  wire logic      clock,
   input  wire logic      reset,
   fipa_req_if.sink       req_bus,
   fipa_rsp_if.source     rsp_bus
);

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type                     state_ff;
   logic [fipa_pkg::ACT_W-1:0]    op_ff;
   logic [fipa_pkg::ID_W-1:0]     ident_ff;
   logic                          rsp_valid_ff;
   logic [fipa_pkg::STA_W-1:0]    rsp_status_ff;
   logic [fipa_pkg::ID_W-1:0]     rsp_ident_ff;

   logic [fipa_pkg::ID_W-1:0]     slot_vec [POOL_SIZE];
   logic [POOL_SIZE-1:0]          used_vec;
   logic [POOL_SIZE-1:0]          tok_vec;
   logic [POOL_SIZE-1:0]          hit_vec;

   fipa_pkg::fipa_ctl_type        ctl;
   logic                          accept;
   logic [fipa_pkg::ID_W-1:0]     grant_sel;
   logic [fipa_pkg::STA_W-1:0]    res_status;
   logic [fipa_pkg::ID_W-1:0]     res_ident;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid & req_bus.ready;

   always_comb begin
      ctl.start   = accept;
      ctl.advance = (state_ff == S_SCAN) && (!rsp_valid_ff || rsp_bus.ready);
      ctl.hit_any = |hit_vec;
      ctl.finish  = ctl.hit_any | tok_vec[POOL_SIZE-1] | (op_ff == fipa_pkg::ACT_RSVD);
      ctl.op      = op_ff;
      ctl.ident   = ident_ff;
   end

   for (genvar i = 0; i < POOL_SIZE; i++) begin : g_cell
      logic                      prv_tok;
      logic [fipa_pkg::ID_W-1:0] nxt_slot;
      logic                      nxt_used;

      if (i == 0) begin : g_head
         assign prv_tok = 1'b0;
      end else begin : g_body
         assign prv_tok = tok_vec[i-1];
      end

      // the tail takes the freed identifier, unused
      if (i == POOL_SIZE - 1) begin : g_tail
         assign nxt_slot = ident_ff;
         assign nxt_used = 1'b0;
      end else begin : g_link
         assign nxt_slot = slot_vec[i+1];
         assign nxt_used = used_vec[i+1];
      end

      fipa_cell #(
         .INDEX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .prv_tok  (prv_tok),
         .nxt_slot (nxt_slot),
         .nxt_used (nxt_used),
         .slot     (slot_vec[i]),
         .used     (used_vec[i]),
         .tok      (tok_vec[i]),
         .hit      (hit_vec[i])
      );
   end

   // at most one cell hits, so an and-or picks its identifier
   always_comb begin
      grant_sel = '0;
      for (int i = 0; i < POOL_SIZE; i++) begin
         grant_sel = grant_sel | (slot_vec[i] & {fipa_pkg::ID_W{hit_vec[i]}});
      end
   end

   always_comb begin
      res_ident = '0;
      if (op_ff == fipa_pkg::ACT_ALLOC) begin
         if (ctl.hit_any) begin
            res_status = fipa_pkg::STAT_GRANTED;
            res_ident  = grant_sel;
         end else begin
            res_status = fipa_pkg::STAT_NONE_FREE;
         end
      end else if (ctl.hit_any) begin
         res_status = fipa_pkg::STAT_RELEASED;
      end else begin
         res_status = fipa_pkg::STAT_NOT_FOUND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a finishing step only happens once the previous beat has left
         rsp_valid_ff <= ((state_ff == S_SCAN) && ctl.advance && ctl.finish)
                         || (rsp_valid_ff && !rsp_bus.ready);
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff    <= req_bus.action;
                  ident_ff <= req_bus.ident;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (ctl.advance && ctl.finish) begin
                  rsp_status_ff <= res_status;
                  rsp_ident_ff  <= res_ident;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.granted_ident = rsp_ident_ff;

   a_tok_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("more than one search token in the chain");

   a_hit_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one cell matched");

   a_idle_no_tok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (tok_vec == '0))
      else $error("search token left in chain while idle");

   a_start_head: assert property (@(posedge clock) disable iff (reset)
      accept |=> (tok_vec[0] && state_ff == S_SCAN))
      else $error("accepted beat did not start a scan at the head cell");

   a_grant_used: assert property (@(posedge clock) disable iff (reset)
      (ctl.advance && ctl.hit_any && op_ff == fipa_pkg::ACT_ALLOC)
      |=> (rsp_status_ff == fipa_pkg::STAT_GRANTED && rsp_ident_ff != '0))
      else $error("grant produced a bad response");

endmodule

`default_nettype wire
